// ----- sv/move_to_front_transform_top_defines.svh -----
// ----------------------------------------------------------------------------
// move-to-front transform: assertion macros
// shared property templates for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef MOVE_TO_FRONT_TRANSFORM_TOP_DEFINES_SVH
`define MOVE_TO_FRONT_TRANSFORM_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define MTF_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MTF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/mtf_pkg.sv -----
// ----------------------------------------------------------------------------
// mtf_pkg
// constants and types shared by the move-to-front cells, queue and top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtf_pkg;

  // alphabet size and symbol width
  localparam int MTF_DEPTH = 256;
  localparam int MTF_SYM_W = 8;

  typedef logic [MTF_SYM_W-1:0] mtf_sym_t;

  // word travelling down the row of cells
  typedef struct packed {
    logic     valid;
    mtf_sym_t sym;
    mtf_sym_t carry;
    logic     found;
    mtf_sym_t rank;
    logic     last;
  } mtf_tok_t;

  // finished result word
  typedef struct packed {
    mtf_sym_t rank;
    logic     last;
  } mtf_res_t;

  // output queue status
  typedef struct packed {
    logic [1:0] count;
    logic       push;
    logic       pop;
  } mtf_q_stat_t;

endpackage

// ----- sv/mtf_cell.sv -----
// ----------------------------------------------------------------------------
// mtf_cell
// one list position: holds its byte, compares and shifts as a word passes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_cell
  import mtf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  mtf_sym_t cell_idx,
  input  mtf_tok_t tok_i,
  output mtf_tok_t tok_o
);

  mtf_sym_t value_r, value_nxt;
  logic     valid_r;
  mtf_sym_t sym_r, carry_r, rank_r;
  logic     found_r, last_r;
  logic     hit;
  mtf_sym_t base;

  // match against this position while the symbol is still unfound
  assign hit = tok_i.valid && !tok_i.found && (value_r == tok_i.sym);

  // new content: shifted-in byte until the symbol is found, identity after block end
  always_comb begin
    base      = tok_i.found ? value_r : tok_i.carry;
    value_nxt = value_r;
    if (tok_i.valid) begin
      value_nxt = tok_i.last ? cell_idx : base;
    end
  end

  // held byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= cell_idx;
    end else if (adv) begin
      value_r <= value_nxt;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= tok_i.valid;
    end
  end

  // stage payload, displaced byte carried to the next cell
  always_ff @(posedge clk) begin
    if (adv) begin
      sym_r   <= tok_i.sym;
      carry_r <= value_r;
      found_r <= tok_i.found || hit;
      rank_r  <= hit ? cell_idx : tok_i.rank;
      last_r  <= tok_i.last;
    end
  end

  assign tok_o = '{valid: valid_r, sym: sym_r, carry: carry_r,
                   found: found_r, rank: rank_r, last: last_r};

endmodule

// ----- sv/mtf_out_q.sv -----
// ----------------------------------------------------------------------------
// mtf_out_q
// two-word result queue between the cell row and the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_out_q
  import mtf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mtf_res_t    push_res,
  input  logic        out_ready,
  output logic        out_valid,
  output mtf_res_t    out_res,
  output mtf_q_stat_t stat
);

  mtf_res_t   entry_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_res   = entry_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_res;
    end
  end

  assign stat = '{count: count_r, push: push, pop: pop};

endmodule

// ----- sv/move_to_front_transform_top.sv -----
// ----------------------------------------------------------------------------
// move_to_front_transform_top
// byte-wise move-to-front encoder built as a row of 256 compare-and-shift cells
// ----------------------------------------------------------------------------
// Each byte word enters the first cell and, while the row advances, moves one
// cell per cycle down it; cell i holds the byte at list position i. A word
// accepts one byte per cycle only while the row advances, and its rank passes
// all 256 cells. Words follow each other back to back, so every word sees the
// list as left by the one before. A two-word result queue lets the row keep
// moving while one result waits; the row stalls only when the queue is full
// and out_ready is low. After reset the list is in identity order at once.
`timescale 1ns / 1ps

`include "move_to_front_transform_top_defines.svh"

module move_to_front_transform_top
  import mtf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  mtf_sym_t in_symbol,
  input  logic     in_block_end,
  output logic     out_valid,
  input  logic     out_ready,
  output mtf_sym_t out_rank,
  output logic     out_rank_last
);

  mtf_tok_t    cell_in  [MTF_DEPTH];
  mtf_tok_t    cell_out [MTF_DEPTH];
  mtf_tok_t    tok_head, tok_tail;
  mtf_res_t    tail_res;
  mtf_res_t    q_res;
  mtf_q_stat_t q_stat;
  logic        adv, push;

  // row advances unless the queue is full and not draining
  assign adv      = (q_stat.count != 2'd2) || out_ready;
  assign in_ready = adv;

  // incoming word: the symbol itself is the byte shifted into position 0
  assign tok_head = '{valid: in_valid, sym: in_symbol, carry: in_symbol,
                      found: 1'b0, rank: '0, last: in_block_end};

  // row of cells
  genvar g;
  generate
    for (g = 0; g < MTF_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign cell_in[g] = tok_head;
      end else begin : g_rest
        assign cell_in[g] = cell_out[g-1];
      end
      mtf_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cell_idx (MTF_SYM_W'(g)),
        .tok_i    (cell_in[g]),
        .tok_o    (cell_out[g])
      );
    end
  endgenerate

  // finished word into the result queue
  assign tok_tail = cell_out[MTF_DEPTH-1];
  assign push     = tok_tail.valid && adv;
  assign tail_res = '{rank: tok_tail.rank, last: tok_tail.last};

  mtf_out_q u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_res  (tail_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (q_res),
    .stat      (q_stat)
  );

  assign out_rank      = q_res.rank;
  assign out_rank_last = q_res.last;

  // every byte sits somewhere in the list, so a word leaving the row has matched
  `MTF_ASSERT_ALWAYS(a_tail_found, !tok_tail.valid || tok_tail.found, "word left row unmatched")
  // queue never overfills
  `MTF_ASSERT_ALWAYS(a_q_bound, q_stat.count <= 2'd2, "result queue overflow")
  // a word pushed without a pop is visible on the output next cycle
  `MTF_ASSERT_NEXT(a_q_push, q_stat.push && !q_stat.pop, out_valid, "pushed word lost")

endmodule

// ----- verif/move_to_front_transform_top_tb.sv -----
// ----------------------------------------------------------------------------
// move_to_front_transform_top_tb
// self-checking bench for the byte-wise move-to-front encoder
// ----------------------------------------------------------------------------
// A short table of directed words runs first. It covers the extremes of the
// list, a byte already in front and block ends. Random blocks follow: most
// use a small alphabet, some use full-range bytes, and the rest are noise
// with stray block ends. A local list model ranks every accepted word and
// queues the expected result. The checker compares each result word with the
// oldest entry in that queue. Both handshake sides idle at random in the first
// two of three phases, and the last phase has no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module move_to_front_transform_top_tb;
  import mtf_pkg::*;

  localparam int RAND_WORDS  = 1125;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 300;

  // one row of the directed table; known marks a hand-typed rank
  typedef struct packed {
    mtf_sym_t sym;
    logic     last;
    logic     known;
    mtf_sym_t rank;
  } dir_row_t;

  localparam int DIR_ROWS = 20;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{8'd0,   1'b0, 1'b1, 8'd0},    // identity, byte already in front
    '{8'd255, 1'b0, 1'b1, 8'd255},  // far end of the list
    '{8'd255, 1'b0, 1'b1, 8'd0},    // repeat stays in front
    '{8'd0,   1'b0, 1'b1, 8'd1},
    '{8'd128, 1'b0, 1'b0, 8'd0},
    '{8'd85,  1'b0, 1'b0, 8'd0},
    '{8'd170, 1'b0, 1'b0, 8'd0},
    '{8'd1,   1'b1, 1'b0, 8'd0},    // block end mid list
    '{8'd200, 1'b0, 1'b1, 8'd200},  // fresh block after end
    '{8'd200, 1'b1, 1'b1, 8'd0},    // block end on a front byte
    '{8'd255, 1'b1, 1'b1, 8'd255},  // single-byte blocks
    '{8'd0,   1'b1, 1'b1, 8'd0},
    '{8'd254, 1'b0, 1'b1, 8'd254},
    '{8'd253, 1'b0, 1'b0, 8'd0},
    '{8'd254, 1'b0, 1'b0, 8'd0},
    '{8'd3,   1'b0, 1'b0, 8'd0},
    '{8'd3,   1'b0, 1'b1, 8'd0},
    '{8'd15,  1'b0, 1'b0, 8'd0},
    '{8'd240, 1'b0, 1'b0, 8'd0},
    '{8'd127, 1'b1, 1'b0, 8'd0}
  };

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  mtf_sym_t in_symbol;
  logic     in_block_end;
  logic     out_valid;
  logic     out_ready;
  mtf_sym_t out_rank;
  logic     out_rank_last;

  // local copy of the list and its inverse index
  mtf_sym_t sym_list [MTF_DEPTH];
  mtf_sym_t sym_pos  [MTF_DEPTH];
  mtf_res_t rank_q [$];

  int tx_idle_pct;
  int rx_idle_pct;
  int fail_cnt;
  int cycle_cnt;

  move_to_front_transform_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_symbol     (in_symbol),
    .in_block_end  (in_block_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rank      (out_rank),
    .out_rank_last (out_rank_last)
  );

  // clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void load_identity_list();
    for (int n = 0; n < MTF_DEPTH; n++) begin
      sym_list[mtf_sym_t'(n)] = mtf_sym_t'(n);
      sym_pos[mtf_sym_t'(n)]  = mtf_sym_t'(n);
    end
  endfunction

  // rank a byte, move it to the front, restore identity at block end
  function automatic mtf_sym_t rank_and_move(input mtf_sym_t sym, input logic last);
    mtf_sym_t pos;
    pos = sym_pos[sym];
    for (int p = int'(pos); p > 0; p--) begin
      sym_list[mtf_sym_t'(p)] = sym_list[mtf_sym_t'(p-1)];
      sym_pos[sym_list[mtf_sym_t'(p)]] = mtf_sym_t'(p);
    end
    sym_list[0] = sym;
    sym_pos[sym] = '0;
    if (last)
      load_identity_list();
    return pos;
  endfunction

  // offer one word, wait for acceptance, queue its expected rank
  task automatic send_word(input mtf_sym_t sym, input logic last, input logic known,
                           input mtf_sym_t known_rank);
    mtf_res_t res;
    mtf_sym_t pred;
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_symbol    <= sym;
    in_block_end <= last;
    do @(posedge clk); while (!in_ready);
    pred = rank_and_move(sym, last);
    res.rank = known ? known_rank : pred;
    res.last = last;
    rank_q.push_back(res);
  endtask

  function automatic void set_phase(input int done);
    if (done < RAND_WORDS / 3) begin
      tx_idle_pct = 34;
      rx_idle_pct = 60;
    end else if (done < 2 * RAND_WORDS / 3) begin
      tx_idle_pct = 60;
      rx_idle_pct = 34;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    mtf_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (rank_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual rank %0d last %0b",
                 $time, out_rank, out_rank_last);
        fail_cnt++;
      end else begin
        e = rank_q.pop_front();
        if (out_rank !== e.rank) begin
          $display("%0t: rank mismatch, expected %0d, actual %0d",
                   $time, e.rank, out_rank);
          fail_cnt++;
        end
        if (out_rank_last !== e.last) begin
          $display("%0t: rank_last mismatch, expected %0b, actual %0b",
                   $time, e.last, out_rank_last);
          fail_cnt++;
        end
      end
    end
    out_ready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("move_to_front_transform_top verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    int       sent;
    int       kind;
    int       len;
    int       alpha_n;
    mtf_sym_t alphabet [16];
    mtf_sym_t sym;
    logic     last;
    dir_row_t row;

    fail_cnt  = 0;
    cycle_cnt = 0;
    sent      = 0;
    load_identity_list();
    set_phase(0);
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_symbol    <= '0;
    in_block_end <= 1'b0;
    out_ready    <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIR_TABLE[5'(r)];
      send_word(row.sym, row.last, row.known, row.rank);
    end

    // random blocks
    while (sent < RAND_WORDS) begin
      kind    = $urandom_range(99);
      len     = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 40);
      alpha_n = $urandom_range(1, 16);
      for (int a = 0; a < 16; a++)
        alphabet[4'(a)] = mtf_sym_t'($urandom_range(255));
      for (int k = 0; k < len && sent < RAND_WORDS; k++) begin
        set_phase(sent);
        if (kind < 60)
          sym = alphabet[4'($urandom_range(alpha_n - 1))];
        else
          sym = mtf_sym_t'($urandom_range(255));
        // noise blocks drop block ends anywhere
        if (kind >= 85)
          last = ($urandom_range(7) == 0);
        else
          last = (k == len - 1);
        send_word(sym, last, 1'b0, '0);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain
    while (rank_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_cnt == 0)
      $display("move_to_front_transform_top verification clean");
    else
      $display("move_to_front_transform_top verification failed");
    $finish;
  end

endmodule
